// ----- rtl/core/cpdn_pkg.sv -----
// Shared constants for the cell pair deduplication and face numbering block.
`default_nettype none

package cpdn_pkg;

  // Fixed field widths of the transactions and registers.
  localparam int CELL_W  = 16;
  localparam int RANK_W  = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int MAX_FACES_DEF = 1024;
  localparam int CELL_BITS_DEF = 16;

  // Widths of the result fields at the default table size.
  localparam int FACE_W_DEF  = $clog2(MAX_FACES_DEF);
  localparam int TOTAL_W_DEF = $clog2(MAX_FACES_DEF + 1);

  // Register indexes, taken from address bit 2.
  localparam logic REG_MY_RANK  = 1'b0;
  localparam logic REG_NBR_RANK = 1'b1;

  // Register reset values.
  localparam logic [RANK_W-1:0] MY_RANK_RST  = 16'd0;
  localparam logic [RANK_W-1:0] NBR_RANK_RST = 16'd1;

endpackage

`default_nettype wire

// ----- rtl/core/cpdn_ifs.sv -----
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none

interface cpdn_in_if;
  logic                         valid;
  logic                         ready;
  logic [cpdn_pkg::CELL_W-1:0]  local_cell;
  logic [cpdn_pkg::CELL_W-1:0]  neighbour_cell;
  logic                         last_of_set;

  modport source (output valid, output local_cell, output neighbour_cell,
                  output last_of_set, input ready);
  modport sink   (input valid, input local_cell, input neighbour_cell,
                  input last_of_set, output ready);
endinterface

interface cpdn_out_if #(
  parameter int FACE_W  = cpdn_pkg::FACE_W_DEF,
  parameter int TOTAL_W = cpdn_pkg::TOTAL_W_DEF
);
  logic                         valid;
  logic                         ready;
  logic [FACE_W-1:0]            coarse_face;
  logic                         is_new;
  logic [cpdn_pkg::CELL_W-1:0]  coarse_cell;
  logic                         overflow;
  logic [TOTAL_W-1:0]           face_total;

  modport source (output valid, output coarse_face, output is_new, output coarse_cell,
                  output overflow, output face_total, input ready);
  modport sink   (input valid, input coarse_face, input is_new, input coarse_cell,
                  input overflow, input face_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cpdn_cell.sv -----
// One key cell of the table chain: holds a key, shifts on insert, compares.
`default_nettype none

module cpdn_cell #(
  parameter int KEY_W = 2 * cpdn_pkg::CELL_BITS_DEF,
  parameter int CNT_W = cpdn_pkg::TOTAL_W_DEF,
  parameter int IDX   = 0
) (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire logic [KEY_W-1:0] key_in,
  input  wire logic [KEY_W-1:0] query,
  input  wire logic [CNT_W-1:0] count,
  output logic      [KEY_W-1:0] key_out,
  output logic                  hit
);

  logic [KEY_W-1:0] key_r;
  logic             hit_r;

  // The cell holds a live key only while its position is below the fill count.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r <= key_in;
    end
    hit_r <= (count > CNT_W'(IDX)) && (key_r == query);
  end

  assign key_out = key_r;
  assign hit     = hit_r;

endmodule

`default_nettype wire

// ----- rtl/core/cpdn_or_tree.sv -----
// Registered OR tree that turns the single hit among the cells into its index.
`default_nettype none

module cpdn_or_tree #(
  parameter int LEAVES = cpdn_pkg::MAX_FACES_DEF,
  parameter int IDX_W  = cpdn_pkg::FACE_W_DEF
) (
  input  wire logic              clk,
  input  wire logic [LEAVES-1:0] hit,
  output logic                   found,
  output logic      [IDX_W-1:0]  idx
);

  localparam int TREE_N = 2 ** IDX_W;

  logic [TREE_N-1:0] hit_pad;
  logic              node_f  [1:2*TREE_N-1];
  logic [IDX_W-1:0]  node_ix [1:2*TREE_N-1];
  logic              stage_f_r  [1:TREE_N-1];
  logic [IDX_W-1:0]  stage_ix_r [1:TREE_N-1];

  assign hit_pad = TREE_N'(hit);

  // Heap layout: node k has children 2k and 2k+1, leaves sit at TREE_N and up.
  // Keys in the table are unique, so at most one leaf is set and OR merges
  // the indexes without a priority choice.
  always_comb begin
    for (int k = 1; k < TREE_N; k++) begin
      node_f[k]  = stage_f_r[k];
      node_ix[k] = stage_ix_r[k];
    end
    for (int j = 0; j < TREE_N; j++) begin
      node_f[TREE_N + j]  = hit_pad[j];
      node_ix[TREE_N + j] = hit_pad[j] ? IDX_W'(j) : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < TREE_N; k++) begin
      stage_f_r[k]  <= node_f[2*k] | node_f[2*k+1];
      stage_ix_r[k] <= node_ix[2*k] | node_ix[2*k+1];
    end
  end

  assign found = stage_f_r[1];
  assign idx   = stage_ix_r[1];

endmodule

`default_nettype wire

// ----- rtl/core/cell_pair_dedup_numbering.sv -----
// Top level: dense coarse face numbering of cell pairs over a chain of key cells.
//
//   Channel   Direction  Handshake               Contents
//   in_ch     in         valid/ready             local_cell, neighbour_cell, last_of_set
//   out_ch    out        valid/ready             coarse_face, is_new, coarse_cell,
//                                                overflow, face_total
//   APB       in/out     psel, penable, pwrite   my_rank (0x0), neighbour_rank (0x4)
//
// Each transaction goes through these steps in order: the block accepts it, all
// cells compare their keys, the levels of the OR tree find the matching cell,
// and the result is built and the key inserted.
// Reset (synchronous, active low) clears the face count and the state machine and
// loads the rank registers; the key cells are not cleared, the fill count alone
// says which of them hold live keys, so the block is ready right after reset.
// A result waits in the output register; the next transaction is accepted meanwhile,
// and only its final step stalls until the output register is free.
`default_nettype none

module cell_pair_dedup_numbering #(
  parameter int MAX_FACES = cpdn_pkg::MAX_FACES_DEF,
  parameter int CELL_BITS = cpdn_pkg::CELL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cpdn_in_if.sink                            in_ch,
  cpdn_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cpdn_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cpdn_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cpdn_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int FACE_W  = $clog2(MAX_FACES);
  localparam int TOTAL_W = $clog2(MAX_FACES + 1);
  localparam int KEY_W   = 2 * CELL_BITS;
  localparam int WAIT_W  = $clog2(FACE_W + 1);
  localparam int CELL_W  = cpdn_pkg::CELL_W;
  localparam int RANK_W  = cpdn_pkg::RANK_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_TREE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers. Address bit 2 picks the register.
  // ---------------------------------------------------------------------------
  logic [RANK_W-1:0] my_rank_r;
  logic [RANK_W-1:0] nbr_rank_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_rank_r  <= cpdn_pkg::MY_RANK_RST;
      nbr_rank_r <= cpdn_pkg::NBR_RANK_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        cpdn_pkg::REG_MY_RANK:  my_rank_r  <= pwdata[RANK_W-1:0];
        cpdn_pkg::REG_NBR_RANK: nbr_rank_r <= pwdata[RANK_W-1:0];
        default:                my_rank_r  <= my_rank_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cpdn_pkg::REG_MY_RANK:  prdata = cpdn_pkg::PDATA_W'(my_rank_r);
      cpdn_pkg::REG_NBR_RANK: prdata = cpdn_pkg::PDATA_W'(nbr_rank_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Key formation. Only the low CELL_BITS bits of each cell number count; the
  // pair is ordered local first when this side has the lower rank, and swapped
  // when the ranks are equal or this side is higher.
  // ---------------------------------------------------------------------------
  logic [CELL_BITS+CELL_W-1:0] loc_wide;
  logic [CELL_BITS+CELL_W-1:0] nbr_wide;
  logic [CELL_BITS-1:0]        loc_c;
  logic [CELL_BITS-1:0]        nbr_c;
  logic [KEY_W-1:0]            key_new;

  assign loc_wide = {{CELL_BITS{1'b0}}, in_ch.local_cell};
  assign nbr_wide = {{CELL_BITS{1'b0}}, in_ch.neighbour_cell};
  assign loc_c    = loc_wide[CELL_BITS-1:0];
  assign nbr_c    = nbr_wide[CELL_BITS-1:0];
  assign key_new  = (my_rank_r < nbr_rank_r) ? {loc_c, nbr_c} : {nbr_c, loc_c};

  // ---------------------------------------------------------------------------
  // Sequencer and per-transaction registers.
  // ---------------------------------------------------------------------------
  logic [1:0]         state_r, state_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [TOTAL_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0]   query_r;
  logic [CELL_W-1:0]  loc_r;
  logic               last_r;
  logic               in_acc;
  logic               load;
  logic               insert;

  logic               root_f;
  logic [FACE_W-1:0]  root_ix;

  logic [FACE_W-1:0]  res_face;
  logic               res_new;
  logic [CELL_W-1:0]  res_cell;
  logic               res_ovf;
  logic [TOTAL_W-1:0] res_total;
  logic [TOTAL_W-1:0] face_hit;
  logic               room;

  logic               out_valid_r, out_valid_nxt;
  logic [FACE_W-1:0]  out_face_r;
  logic               out_new_r;
  logic [CELL_W-1:0]  out_cell_r;
  logic               out_ovf_r;
  logic [TOTAL_W-1:0] out_total_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);
  assign load        = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Cells shift toward higher positions on insert, so the newest key sits in
  // cell 0 and face n lives in cell count - 1 - n.
  assign face_hit = count_r - TOTAL_W'(1) - TOTAL_W'(root_ix);
  assign room     = count_r < TOTAL_W'(MAX_FACES);

  always_comb begin
    res_face  = '0;
    res_new   = 1'b0;
    res_cell  = '0;
    res_ovf   = 1'b0;
    res_total = count_r;
    if (root_f) begin
      res_face = face_hit[FACE_W-1:0];
    end else if (room) begin
      res_face  = count_r[FACE_W-1:0];
      res_new   = 1'b1;
      res_cell  = loc_r;
      res_total = count_r + TOTAL_W'(1);
    end else begin
      res_ovf = 1'b1;
    end
  end

  assign insert = load && !root_f && room;

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_TREE;
        wait_nxt  = WAIT_W'(FACE_W - 1);
      end
      ST_TREE: begin
        if (wait_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          wait_nxt = wait_r - WAIT_W'(1);
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
          count_nxt = last_r ? '0 : res_total;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      query_r <= key_new;
      loc_r   <= CELL_W'(loc_c);
      last_r  <= in_ch.last_of_set;
    end
  end

  // ---------------------------------------------------------------------------
  // Chain of key cells and the OR tree over their hit flags.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]     chain [MAX_FACES];
  logic [MAX_FACES-1:0] hits;

  for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
    logic [KEY_W-1:0] kin;
    if (i == 0) begin : g_head
      assign kin = query_r;
    end else begin : g_link
      assign kin = chain[i-1];
    end
    cpdn_cell #(
      .KEY_W (KEY_W),
      .CNT_W (TOTAL_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .shift_en (insert),
      .key_in   (kin),
      .query    (query_r),
      .count    (count_r),
      .key_out  (chain[i]),
      .hit      (hits[i])
    );
  end

  cpdn_or_tree #(
    .LEAVES (MAX_FACES),
    .IDX_W  (FACE_W)
  ) u_tree (
    .clk   (clk),
    .hit   (hits),
    .found (root_f),
    .idx   (root_ix)
  );

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  assign out_valid_nxt = load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_face_r  <= res_face;
      out_new_r   <= res_new;
      out_cell_r  <= res_cell;
      out_ovf_r   <= res_ovf;
      out_total_r <= res_total;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.coarse_face = out_face_r;
  assign out_ch.is_new      = out_new_r;
  assign out_ch.coarse_cell = out_cell_r;
  assign out_ch.overflow    = out_ovf_r;
  assign out_ch.face_total  = out_total_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // Stored keys are unique, so no more than one cell may match a query.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TREE) |-> $onehot0(hits))
    else $error("more than one cell matched the query key");

  // A matching cell must lie inside the filled part of the chain.
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && root_f) |-> (TOTAL_W'(root_ix) < count_r))
    else $error("matching cell index beyond the fill count");

  // A result never claims both a new face and a full table.
  a_new_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_ovf_r))
    else $error("result marks both a new face and overflow");

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load) |-> (count_r <= TOTAL_W'(MAX_FACES)))
    else $error("face count exceeds the table size");

endmodule

`default_nettype wire

// ----- dv/cell_pair_dedup_numbering_tb.sv -----
// Self-checking testbench for the cell pair deduplication and face numbering block.
`timescale 1ns / 1ps

module cell_pair_dedup_numbering_tb;

  localparam int FACES   = cpdn_pkg::MAX_FACES_DEF;
  localparam int FACE_W  = cpdn_pkg::FACE_W_DEF;
  localparam int TOTAL_W = cpdn_pkg::TOTAL_W_DEF;
  localparam int CELL_W  = cpdn_pkg::CELL_W;
  localparam int RANK_W  = cpdn_pkg::RANK_W;
  localparam int PADDR_W = cpdn_pkg::PADDR_W;
  localparam int PDATA_W = cpdn_pkg::PDATA_W;
  localparam int KEY_W   = 2 * CELL_W;
  // The settle time covers a full search and leaves room for a result in flight.
  localparam int SETTLE_CYCLES = 2 * (FACE_W + 3);

  // One result transaction as the predictor expects it.
  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic               is_new;
    logic [CELL_W-1:0]  new_cell;
    logic               ovf;
    logic [TOTAL_W-1:0] total;
  } face_result_t;

  // Receiver stall patterns. Each one runs for a random number of cycles.
  typedef enum {RX_OPEN, RX_COIN, RX_HOLD, RX_TOGGLE} rx_pattern_t;

  // Predicts the face numbering and checks results in order.
  class face_numbering_board;
    logic [RANK_W-1:0] own_rank;
    logic [RANK_W-1:0] peer_rank;
    logic [KEY_W-1:0]  pair_keys [FACES];
    int unsigned       faces_held;
    face_result_t      awaited [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       created;
    int unsigned       reused;
    int unsigned       overflowed;
    int unsigned       sets_closed;

    function new();
      own_rank    = cpdn_pkg::MY_RANK_RST;
      peer_rank   = cpdn_pkg::NBR_RANK_RST;
      faces_held  = 0;
      errors      = 0;
      checked     = 0;
      created     = 0;
      reused      = 0;
      overflowed  = 0;
      sets_closed = 0;
    endfunction

    function void set_rank(logic idx, logic [RANK_W-1:0] value);
      if (idx == cpdn_pkg::REG_MY_RANK) begin
        own_rank = value;
      end else begin
        peer_rank = value;
      end
    endfunction

    // Works out the result of one accepted face and queues it.
    function void note_face(logic [CELL_W-1:0] loc, logic [CELL_W-1:0] nbr, logic last);
      logic [KEY_W-1:0] key;
      face_result_t     res;
      bit               hit;
      int unsigned      n;
      // The lower rank puts its own cell first; equal ranks swap the pair.
      key = (own_rank < peer_rank) ? {loc, nbr} : {nbr, loc};
      res = '0;
      hit = 1'b0;
      for (n = 0; n < faces_held; n++) begin
        if (pair_keys[n] == key) begin
          hit = 1'b1;
          res.face = FACE_W'(n);
          break;
        end
      end
      if (hit) begin
        reused++;
      end else if (faces_held < FACES) begin
        res.face = FACE_W'(faces_held);
        pair_keys[faces_held] = key;
        faces_held++;
        res.is_new = 1'b1;
        res.new_cell = loc;
        created++;
      end else begin
        // A full table drops the new pair and flags it.
        res.ovf = 1'b1;
        overflowed++;
      end
      res.total = TOTAL_W'(faces_held);
      awaited.push_back(res);
      if (last) begin
        faces_held = 0;
        sets_closed++;
      end
    endfunction

    function void check_result(face_result_t got);
      face_result_t want;
      if (awaited.size() == 0) begin
        $error("Result transaction with no face pending: coarse_face %0d", got.face);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.face !== want.face) begin
        $error("coarse_face: expected %0d, actual %0d", want.face, got.face);
        errors++;
      end
      if (got.is_new !== want.is_new) begin
        $error("is_new: expected %0d, actual %0d", want.is_new, got.is_new);
        errors++;
      end
      if (got.new_cell !== want.new_cell) begin
        $error("coarse_cell: expected 0x%04h, actual 0x%04h", want.new_cell, got.new_cell);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflow: expected %0d, actual %0d", want.ovf, got.ovf);
        errors++;
      end
      if (got.total !== want.total) begin
        $error("face_total: expected %0d, actual %0d", want.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  cpdn_in_if  in_ch ();
  cpdn_out_if out_ch ();

  cell_pair_dedup_numbering dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  face_numbering_board board = new();

  // Sender burst state. When sender_idles is clear the input stream runs back to back.
  bit          sender_idles;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned rank_settings;

  // Cells used while filling the table, so that earlier pairs can be sent again.
  logic [CELL_W-1:0] fill_loc [FACES];

  rx_pattern_t rx_pattern;
  int unsigned rx_left;

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls on its own schedule: stretches of always ready, coin
  // flips, holds with ready low and strict alternation, each for a random length.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left = (rx_pattern == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(8, 60);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_OPEN: begin
        out_ch.ready <= 1'b1;
      end
      RX_COIN: begin
        out_ch.ready <= ($urandom_range(0, 1) == 1);
      end
      RX_HOLD: begin
        out_ch.ready <= 1'b0;
      end
      default: begin
        out_ch.ready <= ~out_ch.ready;
      end
    endcase
  end

  // Every result transaction is checked at the edge that accepts it.
  always @(posedge clk) begin : result_monitor
    face_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.face     = out_ch.coarse_face;
      got.is_new   = out_ch.is_new;
      got.new_cell = out_ch.coarse_cell;
      got.ovf      = out_ch.overflow;
      got.total    = out_ch.face_total;
      board.check_result(got);
    end
  end

  // Offers one face and waits until the block takes it. Afterwards the sender
  // either keeps valid high for the next face or drops it for a random gap.
  task automatic send_face(input logic [CELL_W-1:0] loc, input logic [CELL_W-1:0] nbr,
                           input logic last);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.local_cell     = loc;
    in_ch.neighbour_cell = nbr;
    in_ch.last_of_set    = last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_face(loc, nbr, last);
    items_sent++;
    if (sender_idles) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Lowers valid and waits until every pending result is back, then lets the
  // search pipeline run dry before anything else happens.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [RANK_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_rank(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_check(input logic idx, input logic [RANK_W-1:0] want);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[RANK_W-1:0] !== want) begin
      $error("prdata: expected 0x%04h, actual 0x%04h", want, prdata[RANK_W-1:0]);
      board.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Only called while the block is idle, so the new ranks apply from the next face.
  task automatic set_ranks(input logic [RANK_W-1:0] mine, input logic [RANK_W-1:0] peer);
    apb_write(cpdn_pkg::REG_MY_RANK, mine);
    apb_write(cpdn_pkg::REG_NBR_RANK, peer);
    apb_check(cpdn_pkg::REG_MY_RANK, mine);
    apb_check(cpdn_pkg::REG_NBR_RANK, peer);
    rank_settings++;
  endtask

  function automatic logic [CELL_W-1:0] pick_cell();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return CELL_W'($urandom);
  endfunction

  // Random sets built from a small pool of cell pairs, so that most faces hit
  // a pair already numbered. Some faces reverse a pooled pair and a few are
  // pure noise. Every call ends on a face that closes its set.
  task automatic random_sets(input int unsigned quota);
    logic [CELL_W-1:0] pool_loc [16];
    logic [CELL_W-1:0] pool_nbr [16];
    int unsigned       pool_size;
    int unsigned       set_len;
    int unsigned       sent;
    int unsigned       i;
    int unsigned       k;
    int unsigned       roll;
    logic              last;
    sent = 0;
    while (sent < quota) begin
      pool_size = $urandom_range(1, 16);
      for (i = 0; i < pool_size; i++) begin
        pool_loc[i] = pick_cell();
        pool_nbr[i] = pick_cell();
      end
      set_len = $urandom_range(1, 40);
      for (i = 0; i < set_len; i++) begin
        // An occasional set runs on into the next pool without closing.
        last = (i == set_len - 1) && ((sent + i + 1 >= quota) || ($urandom_range(0, 9) != 0));
        k = $urandom_range(0, pool_size - 1);
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          send_face(pick_cell(), pick_cell(), last);
        end else if (roll <= 2) begin
          send_face(pool_nbr[k], pool_loc[k], last);
        end else begin
          send_face(pool_loc[k], pool_nbr[k], last);
        end
      end
      sent += set_len;
    end
  endtask

  // Fills the table to the last entry with distinct pairs, mixing in repeats,
  // then drives new pairs into the full table alongside pairs it still holds.
  task automatic fill_table();
    logic [FACE_W-1:0] salt;
    int unsigned       n;
    int unsigned       k;
    int unsigned       i;
    salt = FACE_W'($urandom);
    n = 0;
    // The neighbour cell is the fill index scrambled below FACES, so pairs stay distinct.
    while (board.faces_held < FACES) begin
      if (n > 0 && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(0, n - 1);
        send_face(fill_loc[k], CELL_W'(FACE_W'(k) ^ salt), 1'b0);
      end else begin
        fill_loc[n] = CELL_W'($urandom);
        send_face(fill_loc[n], CELL_W'(FACE_W'(n) ^ salt), 1'b0);
        n++;
      end
    end
    // Neighbour cells with the top bit set can never match a stored pair.
    send_face('0, '1, 1'b0);
    send_face('1, '1, 1'b0);
    for (i = 0; i < 30; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_face(CELL_W'($urandom), CELL_W'($urandom) | 16'h8000, 1'b0);
      end else begin
        k = $urandom_range(0, n - 1);
        send_face(fill_loc[k], CELL_W'(FACE_W'(k) ^ salt), 1'b0);
      end
    end
    k = n - 1;
    send_face(fill_loc[k], CELL_W'(FACE_W'(k) ^ salt), 1'b1);
  endtask

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.local_cell     = '0;
    in_ch.neighbour_cell = '0;
    in_ch.last_of_set    = 1'b0;
    out_ch.ready         = 1'b0;
    rx_pattern           = RX_OPEN;
    rx_left              = 0;
    sender_idles         = 1'b1;
    burst_left           = 0;
    items_sent           = 0;
    rank_settings        = 1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The rank registers must come out of reset with their default values.
    apb_check(cpdn_pkg::REG_MY_RANK, cpdn_pkg::MY_RANK_RST);
    apb_check(cpdn_pkg::REG_NBR_RANK, cpdn_pkg::NBR_RANK_RST);

    // Default ranks put this side first, so a pair and its reverse are
    // different faces. A repeated pair must return its old number, and a
    // closing face empties the table after it has been numbered.
    send_face(16'h0000, 16'h0000, 1'b0);
    send_face(16'hFFFF, 16'hFFFF, 1'b0);
    send_face(16'h0000, 16'hFFFF, 1'b0);
    send_face(16'hFFFF, 16'h0000, 1'b0);
    send_face(16'h0000, 16'h0000, 1'b0);
    send_face(16'h0000, 16'hFFFF, 1'b1);
    send_face(16'h0000, 16'hFFFF, 1'b0);
    send_face(16'h5555, 16'hAAAA, 1'b0);
    send_face(16'hAAAA, 16'h5555, 1'b1);
    send_face(16'h1234, 16'h1234, 1'b1);
    // This pair stays in the table across the rank change below.
    send_face(16'h00AB, 16'h00CD, 1'b0);
    settle();

    // Equal ranks swap the pair, so the reversed cells now find the stored
    // face while the original order makes a new one.
    set_ranks(16'd7, 16'd7);
    send_face(16'h00CD, 16'h00AB, 1'b0);
    send_face(16'h00AB, 16'h00CD, 1'b0);
    send_face(16'h8001, 16'h7FFE, 1'b1);
    settle();

    set_ranks(16'hFFFF, 16'h0000);
    send_face(16'hFFFF, 16'h0000, 1'b0);
    send_face(16'h0000, 16'hFFFF, 1'b0);
    send_face(16'hFFFF, 16'h0000, 1'b1);
    settle();

    set_ranks(16'h0000, 16'hFFFF);
    send_face(16'hFFFF, 16'h0001, 1'b1);
    settle();

    // Random sets under a spread of rank settings, one of them without any
    // sender gaps.
    set_ranks(16'h0000, 16'h0001);
    random_sets(90);
    settle();

    set_ranks(16'hFFFF, 16'hFFFF);
    sender_idles = 1'b0;
    random_sets(80);
    settle();
    sender_idles = 1'b1;

    set_ranks(CELL_W'($urandom), CELL_W'($urandom));
    random_sets(90);
    settle();

    set_ranks(16'h0000, 16'h0000);
    random_sets(80);
    settle();

    set_ranks(16'hFFFF, 16'h0000);
    random_sets(90);
    settle();

    // Full table with swapped keys.
    set_ranks(16'd300, 16'd200);
    fill_table();
    settle();

    // A short run after the full table shows that numbering restarts from zero.
    set_ranks(16'h0001, 16'hFFFE);
    random_sets(30);
    settle();

    $display("Covered %0d face transactions under %0d rank settings, %0d results checked.",
             items_sent, rank_settings, board.checked);
    $display("New faces %0d, repeated pairs %0d, full-table drops %0d, sets closed %0d.",
             board.created, board.reused, board.overflowed, board.sets_closed);
    if (board.errors == 0) begin
      $display("cell_pair_dedup_numbering: match");
    end else begin
      $display("cell_pair_dedup_numbering: mismatch");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run with every stall at its longest.
  initial begin
    #8_000_000;
    $display("Timed out with %0d results still pending.", board.awaited.size());
    $display("cell_pair_dedup_numbering: mismatch");
    $finish;
  end

endmodule
